[hdl/tpa_pkg.sv]
`timescale 1ns / 1ps

package tpa_pkg;

    // Width of a handle ID on the ports and in the configuration register.
    localparam int ID_W = 7;

    // Width of the payload length on the ports.
    localparam int LEN_PORT_W = 16;

    // Width of the byte usage counter and of the budget limit.
    localparam int BYTES_W = 32;

    // Reset values of the configuration registers.
    localparam logic [ID_W-1:0]    ID_LIMIT_RESET      = 7'd64;
    localparam logic               GENERATE_MODE_RESET = 1'b1;
    localparam logic               BUDGET_ENABLE_RESET = 1'b0;
    localparam logic [BYTES_W-1:0] BUDGET_LIMIT_RESET  = 32'hFFFF_FFFF;

    // Request kinds.
    typedef enum logic [1:0] {
        ACT_CREATE_GEN = 2'd0,
        ACT_CREATE_ID  = 2'd1,
        ACT_REMOVE     = 2'd2,
        ACT_LOOKUP     = 2'd3
    } t_action;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ILLEGAL   = 3'd1,
        ST_NO_BUDGET = 3'd2,
        ST_BUSY      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // Configuration register indexes (word address on the register port).
    typedef enum logic [1:0] {
        REG_ID_LIMIT      = 2'd0,
        REG_GENERATE_MODE = 2'd1,
        REG_BUDGET_ENABLE = 2'd2,
        REG_BUDGET_LIMIT  = 2'd3
    } t_reg_index;

endpackage

[hdl/tpa_lowest_free.sv]
`timescale 1ns / 1ps

// Finds the lowest set bit of a free-ID bitmap and returns its position.
module tpa_lowest_free #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0]         i_vec,
    output logic                     o_found,
    output logic [$clog2(WIDTH)-1:0] o_index
);

    localparam int IDX_W = $clog2(WIDTH);

    logic [WIDTH-1:0] w_isolated;

    // Keep only the lowest set bit; the result is one-hot or zero.
    assign w_isolated = i_vec & (~i_vec + {{(WIDTH-1){1'b0}}, 1'b1});
    assign o_found    = |i_vec;

    // Encode the one-hot position; each bit contributes independently.
    always_comb begin
        o_index = '0;
        for (int k = 0; k < WIDTH; k++) begin
            if (w_isolated[k]) begin
                o_index = o_index | IDX_W'(k);
            end
        end
    end

endmodule

[hdl/two_pool_id_allocator.sv]
`timescale 1ns / 1ps

// Handle allocator with delayed ID reuse.
// Request channel: a transaction is taken at a rising edge where start is high
// and busy is low. busy never rises, so one request is taken every cycle.
// Each request (create with a generated ID, create with a given ID, remove,
// lookup) produces exactly one result, shown on o_status, o_result_id and
// o_found_length for one cycle while o_valid is high. That cycle begins at the
// edge after the request was taken. The request is registered, then all
// bitmap lookups, the lowest-free-ID search in both pools and the byte budget
// update settle combinationally and land in the result register, so
// throughput is one request per cycle. The payload length memory is read at
// the edge that takes the request, with forwarding from the request that
// completes at that same edge.
// Configuration: APB-style register port, four 32-bit registers at byte
// addresses 0, 4, 8 and 12 (ID limit, generate mode, budget enable, budget
// limit); write only while no request is in flight.
// Reset (synchronous, active low) empties every handle, fills pool zero,
// empties pool one, clears byte usage and restores the register defaults.
// Stored lengths are not cleared; they are written before any read.
module two_pool_id_allocator #(
    parameter int NUM_IDS         = 64,
    parameter int LENGTH_WIDTH    = 16,
    parameter int HANDLE_OVERHEAD = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request channel
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_action,
    input  logic [tpa_pkg::ID_W-1:0]         i_item_id,
    input  logic [tpa_pkg::LEN_PORT_W-1:0]   i_payload_length,
    // Result channel
    output logic                             o_valid,
    output logic [2:0]                       o_status,
    output logic [tpa_pkg::ID_W-1:0]         o_result_id,
    output logic [tpa_pkg::LEN_PORT_W-1:0]   o_found_length,
    // Register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int ID_W    = tpa_pkg::ID_W;
    localparam int BYTES_W = tpa_pkg::BYTES_W;
    localparam int IW      = $clog2(NUM_IDS);
    // Stored length width: the port carries at most LEN_PORT_W bits.
    localparam int LW      = (LENGTH_WIDTH < tpa_pkg::LEN_PORT_W) ?
                             LENGTH_WIDTH : tpa_pkg::LEN_PORT_W;
    // Largest ID that fits both the ID field and the storage.
    localparam int ID_CAP_INT = (NUM_IDS < (2**ID_W - 1)) ? NUM_IDS : (2**ID_W - 1);
    localparam logic [ID_W-1:0]    ID_CAP   = ID_W'(ID_CAP_INT);
    localparam logic [BYTES_W:0]   OVERHEAD = (BYTES_W+1)'(HANDLE_OVERHEAD);

    // Map an ID (1-based) to its storage index.
    function automatic logic [IW-1:0] idx_of(input logic [ID_W-1:0] id);
        logic [ID_W-1:0]    m;
        logic [IW+ID_W-1:0] w;
        m = id - ID_W'(1);
        w = {{IW{1'b0}}, m};
        return w[IW-1:0];
    endfunction

    // Map a storage index back to its ID.
    function automatic logic [ID_W-1:0] id_of(input logic [IW-1:0] idx);
        logic [IW+ID_W-1:0] w;
        w = {{ID_W{1'b0}}, idx};
        return w[ID_W-1:0] + ID_W'(1);
    endfunction

    // Bitmap of storage indexes whose ID lies within the given limit.
    function automatic logic [NUM_IDS-1:0] limit_mask(input logic [ID_W-1:0] lim);
        logic [NUM_IDS-1:0] m;
        m = '0;
        for (int k = 0; k < NUM_IDS; k++) begin
            m[k] = (k < int'(lim));
        end
        return m;
    endfunction

    // Configuration registers
    logic [ID_W-1:0]    r_id_limit;
    logic               r_gen_mode;
    logic               r_budget_enable;
    logic [BYTES_W-1:0] r_budget_limit;
    logic [NUM_IDS-1:0] r_limit_mask;
    logic               w_cfg_write;
    tpa_pkg::t_reg_index w_cfg_index;

    // Request register
    logic                r_req_valid;
    tpa_pkg::t_action    r_req_action;
    logic [ID_W-1:0]     r_req_id;
    logic [LW-1:0]       r_req_len;
    logic [LW-1:0]       r_rd_len;
    logic                w_accept;
    logic [IW-1:0]       w_acc_idx;

    // Allocator state
    logic [NUM_IDS-1:0]  r_in_use, n_in_use;
    logic [NUM_IDS-1:0]  r_pool0, n_pool0;
    logic [NUM_IDS-1:0]  r_pool1, n_pool1;
    logic                r_active, n_active;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;
    logic [LW-1:0]       r_len_mem [NUM_IDS];

    // Result register
    logic                r_valid;
    tpa_pkg::t_status    r_status, n_status;
    logic [ID_W-1:0]     r_rid, n_rid;
    logic [LW-1:0]       r_flen, n_flen;

    // Processing signals
    logic [IW-1:0]       w_sel_idx;
    logic [ID_W-1:0]     w_eff_limit;
    logic                w_in_range;
    logic                w_mode_bad;
    logic                w_over_budget;
    logic [NUM_IDS-1:0]  w_act_free, w_oth_free;
    logic                w_act_found, w_oth_found;
    logic [IW-1:0]       w_act_idx, w_oth_idx;
    logic                w_do_create;
    logic                w_we;
    logic [IW-1:0]       w_idx;
    logic [BYTES_W:0]    w_sum;
    logic [BYTES_W:0]    w_sub;

    // Register port: writes on the access phase, reads decode the word address.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;
    assign w_cfg_index = tpa_pkg::t_reg_index'(paddr[3:2]);

    always_comb begin
        case (w_cfg_index)
            tpa_pkg::REG_ID_LIMIT:      prdata = {{(32-ID_W){1'b0}}, r_id_limit};
            tpa_pkg::REG_GENERATE_MODE: prdata = {31'd0, r_gen_mode};
            tpa_pkg::REG_BUDGET_ENABLE: prdata = {31'd0, r_budget_enable};
            tpa_pkg::REG_BUDGET_LIMIT:  prdata = r_budget_limit;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_limit      <= tpa_pkg::ID_LIMIT_RESET;
            r_gen_mode      <= tpa_pkg::GENERATE_MODE_RESET;
            r_budget_enable <= tpa_pkg::BUDGET_ENABLE_RESET;
            r_budget_limit  <= tpa_pkg::BUDGET_LIMIT_RESET;
            r_limit_mask    <= limit_mask(tpa_pkg::ID_LIMIT_RESET);
        end else if (w_cfg_write) begin
            case (w_cfg_index)
                tpa_pkg::REG_ID_LIMIT: begin
                    r_id_limit   <= pwdata[ID_W-1:0];
                    r_limit_mask <= limit_mask(pwdata[ID_W-1:0]);
                end
                tpa_pkg::REG_GENERATE_MODE: r_gen_mode      <= pwdata[0];
                tpa_pkg::REG_BUDGET_ENABLE: r_budget_enable <= pwdata[0];
                tpa_pkg::REG_BUDGET_LIMIT:  r_budget_limit  <= pwdata;
                default: ;
            endcase
        end
    end

    // Request intake: every cycle can take a transaction.
    assign busy      = 1'b0;
    assign w_accept  = start && !busy;
    assign w_acc_idx = idx_of(i_item_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_action <= tpa_pkg::t_action'(i_action);
            r_req_id     <= i_item_id;
            r_req_len    <= i_payload_length[LW-1:0];
        end
    end

    // Length memory: one write port from processing, one registered read at
    // intake, forwarded when the completing request writes the same entry.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_len_mem[w_idx] <= r_req_len;
        end
        if (w_accept) begin
            if (w_we && (w_idx == w_acc_idx)) begin
                r_rd_len <= r_req_len;
            end else begin
                r_rd_len <= r_len_mem[w_acc_idx];
            end
        end
    end

    // Index, range, mode and budget checks used by the request kinds.
    assign w_sel_idx     = idx_of(r_req_id);
    assign w_eff_limit   = (r_id_limit > ID_CAP) ? ID_CAP : r_id_limit;
    assign w_in_range    = (r_req_id != '0) && (r_req_id <= w_eff_limit);
    assign w_mode_bad    = (r_req_action == tpa_pkg::ACT_CREATE_GEN) ? !r_gen_mode :
                           (r_gen_mode || !w_in_range);
    assign w_over_budget = r_budget_enable && (r_bytes >= r_budget_limit);

    // Usable free IDs in the active and the other pool.
    assign w_act_free = (r_active ? r_pool1 : r_pool0) & ~r_in_use & r_limit_mask;
    assign w_oth_free = (r_active ? r_pool0 : r_pool1) & ~r_in_use & r_limit_mask;

    tpa_lowest_free #(
        .WIDTH (NUM_IDS)
    ) u_act_lowest (
        .i_vec   (w_act_free),
        .o_found (w_act_found),
        .o_index (w_act_idx)
    );

    tpa_lowest_free #(
        .WIDTH (NUM_IDS)
    ) u_oth_lowest (
        .i_vec   (w_oth_free),
        .o_found (w_oth_found),
        .o_index (w_oth_idx)
    );

    // Byte usage arithmetic: saturating add on create, floored subtract on remove.
    assign w_sum = {1'b0, r_bytes} + (BYTES_W+1)'(r_req_len) + OVERHEAD;
    assign w_sub = (BYTES_W+1)'(r_rd_len) + OVERHEAD;

    // Single-pass request processing and state update.
    always_comb begin
        n_status    = tpa_pkg::ST_OK;
        n_rid       = '0;
        n_flen      = '0;
        n_in_use    = r_in_use;
        n_pool0     = r_pool0;
        n_pool1     = r_pool1;
        n_active    = r_active;
        n_bytes     = r_bytes;
        w_do_create = 1'b0;
        w_idx       = w_sel_idx;
        if (r_req_valid) begin
            case (r_req_action)
                tpa_pkg::ACT_CREATE_GEN,
                tpa_pkg::ACT_CREATE_ID: begin
                    if (w_mode_bad) begin
                        n_status = tpa_pkg::ST_ILLEGAL;
                    end else if (w_over_budget) begin
                        n_status = tpa_pkg::ST_NO_BUDGET;
                    end else if (r_req_action == tpa_pkg::ACT_CREATE_GEN) begin
                        if (w_act_found) begin
                            w_idx       = w_act_idx;
                            w_do_create = 1'b1;
                            if (r_active) begin
                                n_pool1[w_act_idx] = 1'b0;
                            end else begin
                                n_pool0[w_act_idx] = 1'b0;
                            end
                        end else begin
                            // Active pool is dry: swap, and stay swapped even if busy.
                            n_active = ~r_active;
                            if (w_oth_found) begin
                                w_idx       = w_oth_idx;
                                w_do_create = 1'b1;
                                if (r_active) begin
                                    n_pool0[w_oth_idx] = 1'b0;
                                end else begin
                                    n_pool1[w_oth_idx] = 1'b0;
                                end
                            end else begin
                                n_status = tpa_pkg::ST_BUSY;
                            end
                        end
                    end else if (r_in_use[w_sel_idx]) begin
                        n_status = tpa_pkg::ST_BUSY;
                    end else begin
                        w_do_create = 1'b1;
                    end
                end
                tpa_pkg::ACT_REMOVE,
                tpa_pkg::ACT_LOOKUP: begin
                    if (!w_in_range) begin
                        n_status = tpa_pkg::ST_ILLEGAL;
                    end else if (!r_in_use[w_sel_idx]) begin
                        n_status = tpa_pkg::ST_NOT_FOUND;
                    end else if (r_req_action == tpa_pkg::ACT_LOOKUP) begin
                        n_rid  = r_req_id;
                        n_flen = r_rd_len;
                    end else begin
                        n_rid                = r_req_id;
                        n_in_use[w_sel_idx]  = 1'b0;
                        // In generate mode, freed IDs go to the inactive pool for delayed reuse.
                        if (r_gen_mode) begin
                            if (r_active) begin
                                n_pool0[w_sel_idx] = 1'b1;
                            end else begin
                                n_pool1[w_sel_idx] = 1'b1;
                            end
                        end
                        n_bytes = ({1'b0, r_bytes} > w_sub) ?
                                  BYTES_W'({1'b0, r_bytes} - w_sub) : '0;
                    end
                end
                default: ;
            endcase
            if (w_do_create) begin
                n_in_use[w_idx] = 1'b1;
                n_rid           = id_of(w_idx);
                n_bytes         = w_sum[BYTES_W] ? {BYTES_W{1'b1}} : w_sum[BYTES_W-1:0];
            end
        end
    end

    assign w_we = w_do_create;

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_pool0  <= '1;
            r_pool1  <= '0;
            r_active <= 1'b0;
            r_bytes  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_in_use <= n_in_use;
            r_pool0  <= n_pool0;
            r_pool1  <= n_pool1;
            r_active <= n_active;
            r_bytes  <= n_bytes;
            r_valid  <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_valid) begin
            r_status <= n_status;
            r_rid    <= n_rid;
            r_flen   <= n_flen;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_result_id    = r_rid;
    assign o_found_length = tpa_pkg::LEN_PORT_W'(r_flen);

`ifndef ASSERT_OFF
    // Every transaction taken yields a result strobe once it has passed the request and result registers.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result strobe missing two cycles after a request");

    // A failed request reports neither an ID nor a length.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != tpa_pkg::ST_OK)) |->
        ((o_result_id == '0) && (o_found_length == '0)))
        else $error("failed request carries an ID or length");

    // A successful create never lowers byte usage.
    a_create_usage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && (n_status == tpa_pkg::ST_OK) &&
         ((r_req_action == tpa_pkg::ACT_CREATE_GEN) ||
          (r_req_action == tpa_pkg::ACT_CREATE_ID)))
        |=> (r_bytes >= $past(r_bytes)))
        else $error("byte usage dropped on a create");

    // Only a generated create may swap the active pool.
    a_pool_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_req_valid || (r_req_action != tpa_pkg::ACT_CREATE_GEN)) |=> $stable(r_active))
        else $error("active pool changed without a generated create");

    // A successful create marks an ID that was free beforehand.
    a_create_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && w_do_create) |-> !r_in_use[w_idx])
        else $error("create picked an ID already in use");
`endif

endmodule

[tb/sv/two_pool_id_allocator_tb.sv]
`timescale 1ns / 1ps

module two_pool_id_allocator_tb;

    localparam int NUM_IDS         = 64;
    localparam int LENGTH_WIDTH    = 16;
    localparam int HANDLE_OVERHEAD = 32;
    localparam int ID_W            = tpa_pkg::ID_W;
    localparam int LEN_PORT_W      = tpa_pkg::LEN_PORT_W;
    localparam int BYTES_W         = tpa_pkg::BYTES_W;

    // Kinds of entries in the stimulus queue.
    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_IDLE,
        OP_REG_WRITE,
        OP_DRAIN
    } t_op_kind;

    typedef enum logic [1:0] {
        APB_OFF,
        APB_SETUP,
        APB_ACCESS
    } t_apb_step;

    typedef struct packed {
        t_op_kind              kind;
        logic [7:0]            count;
        tpa_pkg::t_action      action;
        logic [ID_W-1:0]       item_id;
        logic [LEN_PORT_W-1:0] length;
        tpa_pkg::t_reg_index   reg_idx;
        logic [31:0]           reg_data;
    } t_stim_op;

    typedef struct packed {
        tpa_pkg::t_status      status;
        logic [ID_W-1:0]       id;
        logic [LEN_PORT_W-1:0] length;
    } t_alloc_outcome;

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   start            = 1'b0;
    logic                   busy;
    logic [1:0]             i_action         = '0;
    logic [ID_W-1:0]        i_item_id        = '0;
    logic [LEN_PORT_W-1:0]  i_payload_length = '0;
    logic                   o_valid;
    logic [2:0]             o_status;
    logic [ID_W-1:0]        o_result_id;
    logic [LEN_PORT_W-1:0]  o_found_length;
    logic                   psel             = 1'b0;
    logic                   penable          = 1'b0;
    logic                   pwrite           = 1'b0;
    logic [3:0]             paddr            = '0;
    logic [31:0]            pwdata           = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Predicted allocator state and configuration.
    logic                   handle_live [1:NUM_IDS];
    logic                   free_ids    [0:1][1:NUM_IDS];
    logic [LEN_PORT_W-1:0]  held_length [1:NUM_IDS];
    logic                   active_pool;
    logic [BYTES_W-1:0]     bytes_in_use;
    logic [ID_W-1:0]        cfg_id_limit;
    logic                   cfg_gen_mode;
    logic                   cfg_budget_en;
    logic [BYTES_W-1:0]     cfg_budget_limit;

    t_stim_op               op_queue[$];
    t_alloc_outcome         pending_outcomes[$];

    t_apb_step              apb_step     = APB_OFF;
    logic                   draining     = 1'b0;
    int unsigned            idle_left    = 0;
    int unsigned            settle_left  = 0;
    int unsigned            requests_taken = 0;
    int unsigned            settings_count = 0;
    int unsigned            error_count  = 0;
    int unsigned            outcome_tally [0:4] = '{0, 0, 0, 0, 0};

    two_pool_id_allocator #(
        .NUM_IDS         (NUM_IDS),
        .LENGTH_WIDTH    (LENGTH_WIDTH),
        .HANDLE_OVERHEAD (HANDLE_OVERHEAD)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_item_id        (i_item_id),
        .i_payload_length (i_payload_length),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_result_id      (o_result_id),
        .o_found_length   (o_found_length),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bring the predicted state to its reset contents.
    task automatic clear_allocator_state();
        for (int i = 1; i <= NUM_IDS; i++) begin
            handle_live[i] = 1'b0;
            free_ids[0][i] = 1'b1;
            free_ids[1][i] = 1'b0;
            held_length[i] = '0;
        end
        active_pool      = 1'b0;
        bytes_in_use     = '0;
        cfg_id_limit     = tpa_pkg::ID_LIMIT_RESET;
        cfg_gen_mode     = tpa_pkg::GENERATE_MODE_RESET;
        cfg_budget_en    = tpa_pkg::BUDGET_ENABLE_RESET;
        cfg_budget_limit = tpa_pkg::BUDGET_LIMIT_RESET;
    endtask

    function automatic int unsigned usable_ids();
        return (32'(cfg_id_limit) < NUM_IDS) ? 32'(cfg_id_limit) : NUM_IDS;
    endfunction

    // Lowest ID that is free in the given pool and not already live; 0 if none.
    function automatic logic [ID_W-1:0] lowest_free_id(logic pool);
        int unsigned lim;
        lim = usable_ids();
        for (int i = 1; i <= int'(lim); i++) begin
            if (free_ids[pool][i] && !handle_live[i]) return ID_W'(i);
        end
        return '0;
    endfunction

    // Apply one request to the predicted state and return its outcome.
    function automatic t_alloc_outcome outcome_of_request(tpa_pkg::t_action act,
                                                          logic [ID_W-1:0] req_id,
                                                          logic [LEN_PORT_W-1:0] len);
        t_alloc_outcome res;
        logic [ID_W-1:0] id;
        logic in_range;
        logic [BYTES_W:0] sum;
        logic [BYTES_W:0] sub;
        res.status = tpa_pkg::ST_OK;
        res.id = '0;
        res.length = '0;
        id = req_id;
        in_range = (id >= ID_W'(1)) && (32'(id) <= usable_ids());
        if (act == tpa_pkg::ACT_CREATE_GEN || act == tpa_pkg::ACT_CREATE_ID) begin
            if ((act == tpa_pkg::ACT_CREATE_GEN) ? !cfg_gen_mode :
                (cfg_gen_mode || !in_range)) begin
                res.status = tpa_pkg::ST_ILLEGAL;
            end else if (cfg_budget_en && bytes_in_use >= cfg_budget_limit) begin
                res.status = tpa_pkg::ST_NO_BUDGET;
            end else begin
                if (act == tpa_pkg::ACT_CREATE_GEN) begin
                    // Fall back to the other pool when the active one is dry.
                    id = lowest_free_id(active_pool);
                    if (id == '0) begin
                        active_pool = !active_pool;
                        id = lowest_free_id(active_pool);
                    end
                    if (id != '0) free_ids[active_pool][id] = 1'b0;
                end else if (handle_live[id]) begin
                    id = '0;
                end
                if (id == '0) begin
                    res.status = tpa_pkg::ST_BUSY;
                end else begin
                    sum = {1'b0, bytes_in_use} + (BYTES_W+1)'(len)
                          + (BYTES_W+1)'(HANDLE_OVERHEAD);
                    bytes_in_use = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
                    handle_live[id] = 1'b1;
                    held_length[id] = len;
                    res.id = id;
                end
            end
        end else if (!in_range) begin
            res.status = tpa_pkg::ST_ILLEGAL;
        end else if (!handle_live[id]) begin
            res.status = tpa_pkg::ST_NOT_FOUND;
        end else if (act == tpa_pkg::ACT_LOOKUP) begin
            res.id = id;
            res.length = held_length[id];
        end else begin
            // A freed ID goes to the inactive pool, and only in generate mode.
            sub = (BYTES_W+1)'(held_length[id]) + (BYTES_W+1)'(HANDLE_OVERHEAD);
            handle_live[id] = 1'b0;
            if (cfg_gen_mode) free_ids[!active_pool][id] = 1'b1;
            bytes_in_use = ({1'b0, bytes_in_use} > sub) ? bytes_in_use - sub[BYTES_W-1:0] : '0;
            res.id = id;
        end
        return res;
    endfunction

    task automatic apply_register_write(logic [3:0] addr, logic [31:0] data);
        case (tpa_pkg::t_reg_index'(addr[3:2]))
            tpa_pkg::REG_ID_LIMIT:      cfg_id_limit = data[ID_W-1:0];
            tpa_pkg::REG_GENERATE_MODE: cfg_gen_mode = data[0];
            tpa_pkg::REG_BUDGET_ENABLE: cfg_budget_en = data[0];
            tpa_pkg::REG_BUDGET_LIMIT:  cfg_budget_limit = data;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        error_count++;
        $display("MISMATCH at %0t ns: %s is %0d, expected %0d", $realtime, field, got, want);
    endtask

    // Stimulus queue builders.
    task automatic queue_request(tpa_pkg::t_action act, int unsigned id,
                                 logic [LEN_PORT_W-1:0] len);
        t_stim_op op;
        op = '0;
        op.kind = OP_REQUEST;
        op.action = act;
        op.item_id = ID_W'(id);
        op.length = len;
        op_queue.push_back(op);
    endtask

    task automatic queue_marker(t_op_kind kind, int unsigned count);
        t_stim_op op;
        op = '0;
        op.kind = kind;
        op.count = 8'(count);
        op_queue.push_back(op);
    endtask

    task automatic queue_register(tpa_pkg::t_reg_index idx, logic [31:0] data);
        t_stim_op op;
        op = '0;
        op.kind = OP_REG_WRITE;
        op.reg_idx = idx;
        op.reg_data = data;
        op_queue.push_back(op);
    endtask

    // Settings change only once every outstanding result has come back.
    task automatic queue_settings(int unsigned lim, bit gen, bit budget_on,
                                  logic [31:0] budget);
        queue_marker(OP_DRAIN, 0);
        queue_register(tpa_pkg::REG_ID_LIMIT, lim);
        queue_register(tpa_pkg::REG_GENERATE_MODE, {31'd0, gen});
        queue_register(tpa_pkg::REG_BUDGET_ENABLE, {31'd0, budget_on});
        queue_register(tpa_pkg::REG_BUDGET_LIMIT, budget);
        settings_count++;
    endtask

    // Mostly well-formed traffic on IDs likely to be live, with some noise.
    task automatic queue_random_phase(int unsigned n, int unsigned idle_pct,
                                      int unsigned lim, bit gen);
        int unsigned burst_left;
        int unsigned gap;
        int unsigned roll;
        int unsigned hot_span;
        tpa_pkg::t_action act;
        int unsigned id;
        logic [LEN_PORT_W-1:0] len;
        burst_left = 0;
        hot_span = (lim < 12) ? lim : 12;
        for (int unsigned k = 0; k < n; k++) begin
            // Geometric idle gap, except inside back-to-back bursts.
            gap = 0;
            if (burst_left != 0) begin
                burst_left--;
            end else if ($urandom_range(0, 99) < 3) begin
                burst_left = $urandom_range(10, 40);
            end else begin
                while (gap < 200 && $urandom_range(0, 99) < idle_pct) gap++;
            end
            if (gap != 0) queue_marker(OP_IDLE, gap);
            if ($urandom_range(0, 199) == 0) queue_marker(OP_DRAIN, 0);

            roll = $urandom_range(0, 99);
            if (roll < 40) act = gen ? tpa_pkg::ACT_CREATE_GEN : tpa_pkg::ACT_CREATE_ID;
            else if (roll < 65) act = tpa_pkg::ACT_REMOVE;
            else if (roll < 88) act = tpa_pkg::ACT_LOOKUP;
            else act = tpa_pkg::t_action'($urandom_range(0, 3));

            if (roll >= 88 && $urandom_range(0, 1) == 1) id = $urandom_range(0, 127);
            else if ($urandom_range(0, 99) < 70) id = $urandom_range(1, hot_span);
            else id = $urandom_range(1, lim);

            roll = $urandom_range(0, 9);
            if (roll < 5) len = LEN_PORT_W'($urandom_range(0, 255));
            else if (roll < 9) len = LEN_PORT_W'($urandom);
            else len = roll[0] ? '1 : '0;

            queue_request(act, id, len);
        end
    endtask

    // Driver: records taken transactions in the predictor, then drives the next entry.
    always @(posedge i_clk) begin : request_driver
        t_stim_op op;
        if (!i_rst_n) begin
            start   <= 1'b0;
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end else begin
            if (start && !busy) begin
                pending_outcomes.push_back(outcome_of_request(tpa_pkg::t_action'(i_action),
                                                              i_item_id, i_payload_length));
                requests_taken++;
            end
            if (psel && penable && pwrite && pready) begin
                apply_register_write(paddr, pwdata);
            end

            if (start && busy) begin
                // The request is held off; keep it on the ports.
            end else if (apb_step == APB_SETUP) begin
                penable  <= 1'b1;
                apb_step = APB_ACCESS;
            end else if (apb_step == APB_ACCESS) begin
                if (pready) begin
                    psel     <= 1'b0;
                    penable  <= 1'b0;
                    pwrite   <= 1'b0;
                    apb_step = APB_OFF;
                end
            end else if (draining) begin
                start <= 1'b0;
                if (pending_outcomes.size() == 0) begin
                    if (settle_left == 0) draining = 1'b0;
                    else settle_left--;
                end
            end else if (idle_left != 0) begin
                start <= 1'b0;
                idle_left--;
            end else if (op_queue.size() == 0) begin
                start <= 1'b0;
            end else begin
                op = op_queue.pop_front();
                case (op.kind)
                    OP_REQUEST: begin
                        start            <= 1'b1;
                        i_action         <= op.action;
                        i_item_id        <= op.item_id;
                        i_payload_length <= op.length;
                    end
                    OP_IDLE: begin
                        start     <= 1'b0;
                        idle_left = 32'(op.count) - 1;
                    end
                    OP_DRAIN: begin
                        start       <= 1'b0;
                        draining    = 1'b1;
                        settle_left = 3;
                    end
                    default: begin
                        start    <= 1'b0;
                        psel     <= 1'b1;
                        penable  <= 1'b0;
                        pwrite   <= 1'b1;
                        paddr    <= {op.reg_idx, 2'b00};
                        pwdata   <= op.reg_data;
                        apb_step = APB_SETUP;
                    end
                endcase
            end
        end
    end

    // Monitor: every result is checked against the oldest prediction.
    always @(posedge i_clk) begin : result_checker
        t_alloc_outcome want;
        if (i_rst_n && o_valid) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(o_status), 0);
            end else begin
                want = pending_outcomes.pop_front();
                outcome_tally[want.status]++;
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_result_id !== want.id)
                    report_mismatch("result_id", 32'(o_result_id), 32'(want.id));
                if (o_found_length !== want.length)
                    report_mismatch("found_length", 32'(o_found_length), 32'(want.length));
            end
        end
    end

    // Watchdog for a hung run.
    initial begin : watchdog
        #5_000_000;
        $display("Timeout: results still outstanding or stimulus not taken");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int unsigned rnd_lim;
        bit rnd_gen;
        clear_allocator_state();

        // Directed: two usable IDs, generated mode, both pools run dry.
        queue_settings(2, 1'b1, 1'b0, 32'hFFFF_FFFF);
        queue_request(tpa_pkg::ACT_CREATE_GEN, 0, 16'h0000);
        queue_request(tpa_pkg::ACT_CREATE_GEN, 0, 16'hFFFF);
        queue_request(tpa_pkg::ACT_CREATE_GEN, 0, 16'h0001);
        queue_request(tpa_pkg::ACT_REMOVE, 1, 16'h0000);
        queue_request(tpa_pkg::ACT_CREATE_GEN, 0, 16'h1234);
        queue_request(tpa_pkg::ACT_LOOKUP, 2, 16'h0000);
        queue_request(tpa_pkg::ACT_LOOKUP, 0, 16'h0000);
        queue_request(tpa_pkg::ACT_LOOKUP, 3, 16'h0000);
        queue_request(tpa_pkg::ACT_REMOVE, 127, 16'h0000);
        queue_request(tpa_pkg::ACT_CREATE_ID, 1, 16'h0010);
        queue_request(tpa_pkg::ACT_REMOVE, 2, 16'h0000);
        queue_request(tpa_pkg::ACT_LOOKUP, 2, 16'h0000);
        queue_request(tpa_pkg::ACT_REMOVE, 2, 16'h0000);

        // Directed: given IDs with a zero budget; legality is checked first.
        queue_settings(64, 1'b0, 1'b1, 32'h0000_0000);
        queue_request(tpa_pkg::ACT_CREATE_ID, 64, 16'h0020);
        queue_request(tpa_pkg::ACT_CREATE_GEN, 0, 16'h0020);
        queue_request(tpa_pkg::ACT_CREATE_ID, 0, 16'h0020);

        // Directed: given IDs until the budget runs out; removal without recycling.
        queue_settings(64, 1'b0, 1'b1, 32'd100000);
        queue_request(tpa_pkg::ACT_CREATE_ID, 3, 16'hAAAA);
        queue_request(tpa_pkg::ACT_CREATE_ID, 3, 16'h0005);
        queue_request(tpa_pkg::ACT_CREATE_ID, 64, 16'hFFFF);
        queue_request(tpa_pkg::ACT_CREATE_ID, 5, 16'h0001);
        queue_request(tpa_pkg::ACT_LOOKUP, 64, 16'h0000);
        queue_request(tpa_pkg::ACT_REMOVE, 64, 16'h0000);
        queue_request(tpa_pkg::ACT_LOOKUP, 64, 16'h0000);

        // Directed: back to generated IDs; the search skips the live ID 3.
        queue_settings(64, 1'b1, 1'b0, 32'hFFFF_FFFF);
        queue_request(tpa_pkg::ACT_CREATE_GEN, 0, 16'h5555);
        queue_request(tpa_pkg::ACT_REMOVE, 3, 16'h0000);

        // Random phases: sender idles 24 percent, then 67, then not at all.
        queue_settings(64, 1'b1, 1'b0, 32'hFFFF_FFFF);
        queue_random_phase(215, 24, 64, 1'b1);
        queue_settings(5, 1'b1, 1'b0, 32'hFFFF_FFFF);
        queue_random_phase(215, 24, 5, 1'b1);
        queue_settings(1, 1'b1, 1'b1, 32'd300000);
        queue_random_phase(215, 24, 1, 1'b1);
        queue_settings(8, 1'b0, 1'b0, 32'hFFFF_FFFF);
        queue_random_phase(215, 67, 8, 1'b0);
        queue_settings(64, 1'b0, 1'b1, 32'hFFFF_FFFF);
        queue_random_phase(215, 67, 64, 1'b0);
        queue_settings(3, 1'b1, 1'b1, 32'd150000);
        queue_random_phase(215, 67, 3, 1'b1);
        queue_settings(16, 1'b0, 1'b1, 32'd120000);
        queue_random_phase(215, 0, 16, 1'b0);
        rnd_lim = $urandom_range(1, 64);
        rnd_gen = 1'($urandom_range(0, 1));
        queue_settings(rnd_lim, rnd_gen, 1'b1, $urandom_range(50000, 400000));
        queue_random_phase(215, 0, rnd_lim, rnd_gen);
        queue_settings(2, 1'b1, 1'b0, 32'hFFFF_FFFF);
        queue_random_phase(215, 0, 2, 1'b1);

        // Synchronous reset, then release at a clock edge.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every queued transaction is taken and answered.
        do begin
            @(negedge i_clk);
        end while (op_queue.size() != 0 || start || apb_step != APB_OFF || draining
                   || idle_left != 0 || pending_outcomes.size() != 0);
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d requests across %0d register settings.",
                 requests_taken, settings_count);
        $display("Outcomes: %0d ok, %0d illegal, %0d no budget, %0d busy, %0d not found.",
                 outcome_tally[tpa_pkg::ST_OK], outcome_tally[tpa_pkg::ST_ILLEGAL],
                 outcome_tally[tpa_pkg::ST_NO_BUDGET], outcome_tally[tpa_pkg::ST_BUSY],
                 outcome_tally[tpa_pkg::ST_NOT_FOUND]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
